>>> hw/rtl/http_chunked_body_decoder_core_macros.svh
// Assertion macros shared by the chunked body decoder checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define HCBD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define HCBD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder: item type, phase and status codes,
// character constants and parameter defaults. No dependencies.
package hcbd_pkg;

   localparam int COUNT_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   // One classified input beat as it travels from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_message;
      logic       end_of_buffer;
      logic       hex_ok;
      logic [3:0] hex_val;
      logic       is_cr;
      logic       is_lf;
      logic       is_semi;
   } hcbd_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } hcbd_queue_status_type;

   typedef enum logic [11:0] {
      PH_SIZE     = 12'b0000_0000_0001,
      PH_EXT      = 12'b0000_0000_0010,
      PH_EXT_CR   = 12'b0000_0000_0100,
      PH_SIZE_LF  = 12'b0000_0000_1000,
      PH_DATA     = 12'b0000_0001_0000,
      PH_DATA_CR  = 12'b0000_0010_0000,
      PH_DATA_LF  = 12'b0000_0100_0000,
      PH_TRAIL_CR = 12'b0000_1000_0000,
      PH_TRAIL_LF = 12'b0001_0000_0000,
      PH_DONE     = 12'b0010_0000_0000,
      PH_ERROR    = 12'b0100_0000_0000,
      PH_INCOMP   = 12'b1000_0000_0000
   } hcbd_phase_type;

   typedef enum logic [2:0] {
      ST_BUSY  = 3'd0,
      ST_BODY  = 3'd1,
      ST_MSG   = 3'd2,
      ST_BAD   = 3'd3,
      ST_SHORT = 3'd4
   } hcbd_status_type;

endpackage

>>> hw/rtl/http_chunked_body_decoder_core.sv
// HTTP/1.1 chunked body decoder, one byte per beat.
// Request channel (req_*): one raw body byte per beat, with start_message to
// begin a new body and end_of_buffer to mark the last byte available.
// Response channel (rsp_*): exactly one result per request beat, in order:
// the payload byte and its valid flag, and a status code (in progress, body
// complete, message complete, malformed, incomplete).
// A byte passes through the front register, the queue and the result register
// before its result is shown.
// Throughput: one byte per cycle while neither side stalls; the parse state
// machine updates once per cycle in which it takes a byte from the queue.
// A stalled response holds in the result register; the item queue and the
// front register keep taking bytes until both are full, then req_stall rises.
// Reset (synchronous, active high) empties the pipeline and returns the parser
// to expecting size digits with a zero count.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
module http_chunked_body_decoder_core
   import hcbd_pkg::*;
#(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_start_message,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic [2:0] rsp_status
);

   logic                  push, pop;
   hcbd_item_type         push_item, head_item;
   hcbd_queue_status_type q_status;

   hcbd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_start_message (req_start_message),
      .req_end_of_buffer (req_end_of_buffer),
      .q_status          (q_status),
      .push              (push),
      .push_item         (push_item)
   );

   hcbd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   hcbd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_item         (head_item),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_status        (rsp_status)
   );

endmodule

>>> hw/rtl/hcbd_front.sv
// Front stage of the chunked body decoder: accepts input beats, classifies
// the byte and hands the item to the queue. Depends on hcbd_pkg.
module hcbd_front
   import hcbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_start_message,
   input  logic                  req_end_of_buffer,
   input  hcbd_queue_status_type q_status,
   output logic                  push,
   output hcbd_item_type         push_item
);

   logic          valid_ff, valid_in;
   hcbd_item_type item_ff, item_in;
   hcbd_item_type item_cls;
   logic          accept;

   // Byte classification
   always_comb begin
      item_cls               = '0;
      item_cls.data_byte     = req_data_byte;
      item_cls.start_message = req_start_message;
      item_cls.end_of_buffer = req_end_of_buffer;
      item_cls.is_cr         = (req_data_byte == CH_CR);
      item_cls.is_lf         = (req_data_byte == CH_LF);
      item_cls.is_semi       = (req_data_byte == CH_SEMI);
      if (req_data_byte >= 8'h30 && req_data_byte <= 8'h39) begin
         item_cls.hex_ok  = 1'b1;
         item_cls.hex_val = req_data_byte[3:0];
      end else if ((req_data_byte >= 8'h41 && req_data_byte <= 8'h46) ||
                   (req_data_byte >= 8'h61 && req_data_byte <= 8'h66)) begin
         item_cls.hex_ok  = 1'b1;
         item_cls.hex_val = 4'(req_data_byte[2:0] + 3'd1) + 4'd8;
      end
   end

   // Hold register; stalls only when it is full and the queue cannot take it
   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !q_status.full;
   assign push_item = item_ff;

   always_comb begin
      valid_in = accept || (valid_ff && q_status.full);
      item_in  = accept ? item_cls : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

>>> hw/rtl/hcbd_queue.sv
// Small FIFO of classified items between front and back of the decoder.
// Depends on hcbd_pkg.
module hcbd_queue
   import hcbd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hcbd_item_type         push_item,
   input  logic                  pop,
   output hcbd_item_type         head_item,
   output hcbd_queue_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hcbd_item_type    mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_item      = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/hcbd_back.sv
// Back stage of the chunked body decoder: parse state machine and result
// register. Depends on hcbd_pkg.
module hcbd_back
   import hcbd_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hcbd_item_type         head_item,
   input  hcbd_queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_payload_byte,
   output logic                  rsp_payload_valid,
   output logic [2:0]            rsp_status
);

   hcbd_phase_type        phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  digit_ff, digit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            pbyte_ff;
   logic                  pvalid_ff;
   hcbd_status_type       status_ff;

   hcbd_phase_type        ph, ph_n;
   logic [COUNT_BITS-1:0] cnt, cnt_n;
   logic                  dig, dig_n;
   logic                  pv;
   hcbd_status_type       st;

   // Take a beat when one waits and the result register is free or draining
   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   // Parse step for the item at the head of the queue
   always_comb begin
      ph  = head_item.start_message ? PH_SIZE : phase_ff;
      cnt = head_item.start_message ? '0 : count_ff;
      dig = head_item.start_message ? 1'b0 : digit_ff;

      ph_n  = ph;
      cnt_n = cnt;
      dig_n = dig;
      pv    = 1'b0;
      st    = ST_BUSY;

      unique case (ph)
         PH_SIZE: begin
            if (head_item.hex_ok) begin
               if (cnt[COUNT_BITS-1 -: 4] != 4'd0) begin
                  ph_n = PH_ERROR;
               end else begin
                  cnt_n = {cnt[COUNT_BITS-5:0], head_item.hex_val};
                  dig_n = 1'b1;
               end
            end else if (head_item.is_semi) begin
               ph_n = dig ? PH_EXT : PH_ERROR;
            end else if (head_item.is_cr) begin
               ph_n = dig ? PH_SIZE_LF : PH_ERROR;
            end else begin
               ph_n = PH_ERROR;
            end
         end
         PH_EXT: begin
            if (head_item.is_cr) begin
               ph_n = PH_EXT_CR;
            end
         end
         PH_SIZE_LF, PH_EXT_CR: begin
            if (head_item.is_lf) begin
               dig_n = 1'b0;
               if (cnt == '0) begin
                  ph_n = PH_TRAIL_CR;
                  st   = ST_BODY;
               end else begin
                  ph_n = PH_DATA;
               end
            end else if (ph == PH_EXT_CR) begin
               if (!head_item.is_cr) begin
                  ph_n = PH_EXT;
               end
            end else begin
               ph_n = PH_ERROR;
            end
         end
         PH_DATA: begin
            pv    = 1'b1;
            cnt_n = cnt - COUNT_BITS'(1);
            if (cnt_n == '0) begin
               ph_n = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            ph_n = head_item.is_cr ? PH_DATA_LF : PH_ERROR;
         end
         PH_DATA_LF: begin
            if (head_item.is_lf) begin
               ph_n  = PH_SIZE;
               cnt_n = '0;
               dig_n = 1'b0;
            end else begin
               ph_n = PH_ERROR;
            end
         end
         PH_TRAIL_CR: begin
            ph_n = head_item.is_cr ? PH_TRAIL_LF : PH_ERROR;
         end
         PH_TRAIL_LF: begin
            if (head_item.is_lf) begin
               ph_n = PH_DONE;
               st   = ST_MSG;
            end else begin
               ph_n = PH_ERROR;
            end
         end
         PH_DONE: begin
            st = ST_MSG;
         end
         PH_INCOMP: begin
            st = ST_SHORT;
         end
         default: begin
            ph_n = PH_ERROR;
         end
      endcase

      // Error and end-of-buffer overrides
      if (ph_n == PH_ERROR) begin
         st = ST_BAD;
         pv = 1'b0;
      end else if (head_item.end_of_buffer && (ph_n inside {PH_SIZE, PH_EXT, PH_EXT_CR,
                   PH_SIZE_LF, PH_DATA, PH_DATA_CR, PH_DATA_LF})) begin
         ph_n = PH_INCOMP;
         st   = ST_SHORT;
      end else if (head_item.end_of_buffer && (ph_n inside {PH_TRAIL_CR, PH_TRAIL_LF})) begin
         st = ST_BODY;
      end
   end

   // State commit
   always_comb begin
      phase_in     = pop ? ph_n : phase_ff;
      count_in     = pop ? cnt_n : count_ff;
      digit_in     = pop ? dig_n : digit_ff;
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         count_ff     <= '0;
         digit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         pbyte_ff  <= pv ? head_item.data_byte : 8'd0;
         pvalid_ff <= pv;
         status_ff <= st;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = pbyte_ff;
   assign rsp_payload_valid = pvalid_ff;
   assign rsp_status        = status_ff;

endmodule

>>> hw/rtl/hcbd_checker.sv
// Port-level checker for the chunked body decoder, bound to the top level.
// Depends on hcbd_pkg and http_chunked_body_decoder_core_macros.svh.
`include "http_chunked_body_decoder_core_macros.svh"

module hcbd_checker
   import hcbd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_payload_valid,
   input logic [2:0] rsp_status
);

   logic rsp_held;
   logic pay_ok_status;

   assign rsp_held      = rsp_valid && rsp_stall;
   assign pay_ok_status = (rsp_status == ST_BUSY) || (rsp_status == ST_SHORT);

   // A stalled result stays offered
   `HCBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "stalled result dropped")
   // A stalled result keeps its payload
   `HCBD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held,
      $stable(rsp_payload_byte) && $stable(rsp_payload_valid) && $stable(rsp_status),
      "stalled result changed")
   // Payload bytes only appear while parsing or when the buffer runs out
   `HCBD_ASSERT_IMPL(a_pay_status, clock, reset, rsp_valid && rsp_payload_valid,
      pay_ok_status, "payload with final status")
   // Non-payload results carry a zero byte
   `HCBD_ASSERT_IMPL(a_pay_zero, clock, reset, rsp_valid && !rsp_payload_valid,
      rsp_payload_byte == 8'd0, "nonzero byte without payload")

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (.*);

>>> tb/sv/tb_http_chunked_body_decoder_core.sv
// Self-checking testbench for http_chunked_body_decoder_core: directed table plus
// random chunked bodies, checked beat by beat against a behavioral decoder.
// Depends on hcbd_pkg and the decoder RTL.
module tb_http_chunked_body_decoder_core
   import hcbd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CNT_W        = COUNT_BITS_DEF;
   localparam int ITEM_COUNT   = 400;
   localparam int STUCK_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT     = 22;

   typedef struct {
      logic [7:0]      pbyte;
      logic            pvalid;
      hcbd_status_type status;
   } chunk_result_type;

   typedef struct {
      logic [7:0]       data;
      logic             start;
      logic             eob;
      logic             typed;
      chunk_result_type want;
   } body_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_start_message = 1'b0;
   logic       req_end_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_payload_valid;
   logic [2:0] rsp_status;

   body_beat_type    body_beats[$];
   body_beat_type    cur_beat;
   chunk_result_type due_results[$];
   chunk_result_type head_result;
   chunk_result_type predicted;
   logic [7:0]       frame_bytes[$];
   int               fail_count = 0;
   int               sent_count = 0;
   int               stuck_cycles = 0;
   logic             in_taken = 1'b0;
   logic             calm;

   // decoder state mirrored by the predictor
   hcbd_phase_type   dec_phase = PH_SIZE;
   logic [CNT_W-1:0] dec_count = '0;
   logic             dec_digit_seen = 1'b0;

   // no idling on either side for a stretch in the middle of the run
   assign calm = (sent_count >= 180) && (sent_count < 280);

   http_chunked_body_decoder_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_start_message (req_start_message),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_status        (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one body byte through the decoder state machine
   function automatic chunk_result_type decode_beat(logic [7:0] b, logic start, logic eob);
      chunk_result_type r;
      logic             is_hex;
      logic [3:0]       nib;
      r.pbyte  = 8'h00;
      r.pvalid = 1'b0;
      r.status = ST_BUSY;
      if (start) begin
         dec_phase      = PH_SIZE;
         dec_count      = '0;
         dec_digit_seen = 1'b0;
      end
      // hex digit, either case: letters map from the low nibble plus nine
      is_hex = 1'b1;
      nib    = b[3:0];
      if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         nib = b[3:0] + 4'd9;
      end else if (!(b >= 8'h30 && b <= 8'h39)) begin
         is_hex = 1'b0;
      end
      case (dec_phase)
         PH_SIZE: begin
            if (is_hex) begin
               if (dec_count > ({CNT_W{1'b1}} >> 4)) begin
                  dec_phase = PH_ERROR;
               end else begin
                  dec_count      = {dec_count[CNT_W-5:0], nib};
                  dec_digit_seen = 1'b1;
               end
            end else if (b == CH_SEMI && dec_digit_seen) begin
               dec_phase = PH_EXT;
            end else if (b == CH_CR && dec_digit_seen) begin
               dec_phase = PH_SIZE_LF;
            end else begin
               dec_phase = PH_ERROR;
            end
         end
         PH_EXT: begin
            if (b == CH_CR) dec_phase = PH_EXT_CR;
         end
         PH_SIZE_LF, PH_EXT_CR: begin
            if (b == CH_LF) begin
               dec_digit_seen = 1'b0;
               if (dec_count == '0) begin
                  dec_phase = PH_TRAIL_CR;
                  r.status  = ST_BODY;
               end else begin
                  dec_phase = PH_DATA;
               end
            end else if (dec_phase == PH_EXT_CR) begin
               // a lone CR inside an extension is just skipped
               if (b != CH_CR) dec_phase = PH_EXT;
            end else begin
               dec_phase = PH_ERROR;
            end
         end
         PH_DATA: begin
            r.pvalid  = 1'b1;
            r.pbyte   = b;
            dec_count = dec_count - 1'b1;
            if (dec_count == '0) dec_phase = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (b == CH_CR) dec_phase = PH_DATA_LF;
            else dec_phase = PH_ERROR;
         end
         PH_DATA_LF: begin
            if (b == CH_LF) begin
               dec_phase      = PH_SIZE;
               dec_count      = '0;
               dec_digit_seen = 1'b0;
            end else begin
               dec_phase = PH_ERROR;
            end
         end
         PH_TRAIL_CR: begin
            if (b == CH_CR) dec_phase = PH_TRAIL_LF;
            else dec_phase = PH_ERROR;
         end
         PH_TRAIL_LF: begin
            if (b == CH_LF) begin
               dec_phase = PH_DONE;
               r.status  = ST_MSG;
            end else begin
               dec_phase = PH_ERROR;
            end
         end
         PH_DONE:   r.status = ST_MSG;
         PH_INCOMP: r.status = ST_SHORT;
         default:   dec_phase = PH_ERROR;
      endcase
      // error wins, then end of buffer before or after body complete
      if (dec_phase == PH_ERROR) begin
         r.status = ST_BAD;
         r.pvalid = 1'b0;
         r.pbyte  = 8'h00;
      end else if (eob && (dec_phase inside {PH_SIZE, PH_EXT, PH_EXT_CR, PH_SIZE_LF,
                                             PH_DATA, PH_DATA_CR, PH_DATA_LF})) begin
         dec_phase = PH_INCOMP;
         r.status  = ST_SHORT;
      end else if (eob && (dec_phase inside {PH_TRAIL_CR, PH_TRAIL_LF})) begin
         r.status = ST_BODY;
      end
      return r;
   endfunction

   function automatic void add_beat(logic [7:0] d, logic s, logic e);
      body_beat_type bb;
      bb.data        = d;
      bb.start       = s;
      bb.eob         = e;
      bb.typed       = 1'b0;
      bb.want.pbyte  = 8'h00;
      bb.want.pvalid = 1'b0;
      bb.want.status = ST_BUSY;
      body_beats.push_back(bb);
   endfunction

   function automatic void add_checked(logic [7:0] d, logic s, logic e, logic [7:0] pb,
                                       logic pv, hcbd_status_type st);
      body_beat_type bb;
      bb.data        = d;
      bb.start       = s;
      bb.eob         = e;
      bb.typed       = 1'b1;
      bb.want.pbyte  = pb;
      bb.want.pvalid = pv;
      bb.want.status = st;
      body_beats.push_back(bb);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(1) ? 8'h41 : 8'h61) + (n - 4'd10);
   endfunction

   // hex size digits, at least min_digits of them
   function automatic void put_hex(logic [31:0] v, int min_digits);
      logic [3:0] nib;
      logic       started;
      started = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         nib = v[i*4 +: 4];
         if (nib != 4'd0 || started || i < min_digits) begin
            started = 1'b1;
            frame_bytes.push_back(hex_char(nib));
         end
      end
   endfunction

   function automatic void put_line_end();
      frame_bytes.push_back(CH_CR);
      frame_bytes.push_back(CH_LF);
   endfunction

   // optional extension, now and then with a stray CR inside
   function automatic void put_extension();
      if ($urandom_range(3) == 0) begin
         frame_bytes.push_back(CH_SEMI);
         repeat ($urandom_range(4)) frame_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
         if ($urandom_range(3) == 0) begin
            frame_bytes.push_back(CH_CR);
            frame_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end
      end
   endfunction

   function automatic void build_directed();
      // full message: extension with a lone CR, one data byte, last chunk, final CRLF
      add_beat("1", 1'b1, 1'b0);
      add_beat(CH_SEMI, 1'b0, 1'b0);
      add_beat(CH_CR, 1'b0, 1'b0);
      add_beat("q", 1'b0, 1'b0);
      add_beat(CH_CR, 1'b0, 1'b0);
      add_beat(CH_LF, 1'b0, 1'b0);
      add_checked(8'hFF, 1'b0, 1'b0, 8'hFF, 1'b1, ST_BUSY);
      add_beat(CH_CR, 1'b0, 1'b0);
      add_beat(CH_LF, 1'b0, 1'b0);
      add_beat("0", 1'b0, 1'b0);
      add_beat(CH_CR, 1'b0, 1'b0);
      add_checked(CH_LF, 1'b0, 1'b0, 8'h00, 1'b0, ST_BODY);
      // buffer ends between body and message complete
      add_checked(CH_CR, 1'b0, 1'b1, 8'h00, 1'b0, ST_BODY);
      add_checked(CH_LF, 1'b0, 1'b0, 8'h00, 1'b0, ST_MSG);
      add_checked(8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_MSG);
      // size overflow on the ninth digit, mixed case, then the error latch
      add_beat("f", 1'b1, 1'b0);
      add_beat("F", 1'b0, 1'b0);
      add_beat("a", 1'b0, 1'b0);
      add_beat("A", 1'b0, 1'b0);
      add_beat("9", 1'b0, 1'b0);
      add_beat("0", 1'b0, 1'b0);
      add_beat("f", 1'b0, 1'b0);
      add_beat("F", 1'b0, 1'b0);
      add_checked("1", 1'b0, 1'b0, 8'h00, 1'b0, ST_BAD);
      add_checked(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, ST_BAD);
      // no digit before the separator, and a stray byte on the size line
      add_checked(CH_SEMI, 1'b1, 1'b0, 8'h00, 1'b0, ST_BAD);
      add_checked("G", 1'b1, 1'b0, 8'h00, 1'b0, ST_BAD);
      // size CR not followed by LF
      add_beat("1", 1'b1, 1'b0);
      add_beat(CH_CR, 1'b0, 1'b0);
      add_checked("Z", 1'b0, 1'b0, 8'h00, 1'b0, ST_BAD);
      // data not followed by CRLF
      add_beat("1", 1'b1, 1'b0);
      add_beat(CH_CR, 1'b0, 1'b0);
      add_beat(CH_LF, 1'b0, 1'b0);
      add_beat("d", 1'b0, 1'b0);
      add_checked("e", 1'b0, 1'b0, 8'h00, 1'b0, ST_BAD);
      // buffer ends early, and the short status latches
      add_checked("1", 1'b1, 1'b1, 8'h00, 1'b0, ST_SHORT);
      add_checked("A", 1'b0, 1'b0, 8'h00, 1'b0, ST_SHORT);
   endfunction

   // one random body: mostly well-formed, some broken, some noise
   function automatic void build_message();
      int         kind;
      int         eob_at;
      int         idx;
      int         len;
      logic       start_first;
      logic [7:0] fill;
      kind        = $urandom_range(99);
      start_first = ($urandom_range(19) != 0);
      eob_at      = -1;
      frame_bytes.delete();
      if (kind < 8) begin
         // raw noise with random control bits
         repeat ($urandom_range(1, 6)) begin
            fill = 8'($urandom_range(255));
            add_beat(fill, $urandom_range(9) == 0, $urandom_range(9) == 0);
         end
         return;
      end
      if (kind < 14) begin
         // huge size, overflowing on a ninth digit half the time
         put_hex($urandom(), 8);
         if ($urandom_range(1)) frame_bytes.push_back(hex_char(4'($urandom_range(15))));
         put_line_end();
         repeat ($urandom_range(3)) frame_bytes.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(3)) begin
            len = $urandom_range(1, 20);
            put_hex(32'(len), $urandom_range(7) == 0 ? 3 : 1);
            put_extension();
            put_line_end();
            repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
            put_line_end();
         end
         put_hex(0, $urandom_range(1, 2));
         put_extension();
         put_line_end();
         put_line_end();
         repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom_range(255)));
         // broken bodies: a replaced byte, a dropped byte, or an early buffer end
         if (kind < 40) begin
            idx = $urandom_range(frame_bytes.size() - 1);
            case ($urandom_range(2))
               0: frame_bytes[idx] = 8'($urandom_range(255));
               1: frame_bytes.delete(idx);
               default: eob_at = idx;
            endcase
         end
      end
      if (eob_at < 0 && $urandom_range(9) < 3) eob_at = frame_bytes.size() - 1;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         add_beat(frame_bytes[i], (i == 0) && start_first, i == eob_at);
      end
   endfunction

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
   end

   // request monitor: predict each accepted beat in order
   always @(posedge clock) begin
      in_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         in_taken = 1'b1;
         sent_count++;
         predicted = decode_beat(req_data_byte, req_start_message, req_end_of_buffer);
         if (cur_beat.typed) due_results.push_back(cur_beat.want);
         else due_results.push_back(predicted);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("result beat with no expected result pending");
            fail_count++;
         end else begin
            head_result = due_results.pop_front();
            if (rsp_payload_byte !== head_result.pbyte) begin
               $error("payload_byte: expected %02h, got %02h",
                      head_result.pbyte, rsp_payload_byte);
               fail_count++;
            end
            if (rsp_payload_valid !== head_result.pvalid) begin
               $error("payload_valid: expected %0d, got %0d",
                      head_result.pvalid, rsp_payload_valid);
               fail_count++;
            end
            if (rsp_status !== head_result.status) begin
               $error("status: expected %0d, got %0d", head_result.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
      end
      $display("tb_http_chunked_body_decoder_core: done, errors");
      $finish;
   end

   // stimulus: table walk, then drain and report
   initial begin
      int beat_idx;
      beat_idx = 0;
      build_directed();
      while (body_beats.size() < ITEM_COUNT) build_message();
      while (body_beats.size() > ITEM_COUNT) void'(body_beats.pop_back());
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (beat_idx < body_beats.size()) begin
         // the beat on the bus was taken at the last rising edge
         if (req_valid && in_taken) beat_idx++;
         if (!req_valid || in_taken) begin
            if (beat_idx < body_beats.size() && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               cur_beat          = body_beats[beat_idx];
               req_valid         <= 1'b1;
               req_data_byte     <= cur_beat.data;
               req_start_message <= cur_beat.start;
               req_end_of_buffer <= cur_beat.eob;
            end else begin
               req_valid <= 1'b0;
            end
         end
         @(negedge clock);
      end
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("tb_http_chunked_body_decoder_core: done, clean");
      else $display("tb_http_chunked_body_decoder_core: done, errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_front.sv
hw/rtl/hcbd_queue.sv
hw/rtl/hcbd_back.sv
hw/rtl/http_chunked_body_decoder_core.sv
hw/rtl/hcbd_checker.sv
tb/sv/tb_http_chunked_body_decoder_core.sv
